@@ rtl/cfa_pkg.sv @@
// Package with the custom float format constants and types.
`timescale 1ns / 1ps
package cfa_pkg;
    localparam int FracW = 26;
    localparam int ExpW  = 5;
    localparam int MantW = FracW + 1;
    localparam int SumW  = MantW + 1;
    localparam logic [ExpW-1:0] ExpMax = 5'h1F;

    typedef struct packed {
        logic             sign;
        logic [ExpW-1:0]  expo;
        logic [FracW-1:0] frac;
    } float_t;

    typedef struct packed {
        logic [31:0] sum;
        logic        overflowed;
        logic        underflowed;
    } result_t;
endpackage

@@ rtl/cfa_stream_if.sv @@
// Valid/ready channel interface carrying one payload.
`timescale 1ns / 1ps
interface cfa_stream_if #(
    parameter type payload_t = logic [31:0]
);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/custom_float_adder.sv @@
// Four-stage pipelined adder for the custom 32-bit float format.
// Throughput: one addition per cycle while out_r is not stalled; a stall freezes every stage at once.
// Reset: rst_n clears all stage valid bits asynchronously; items in flight are dropped.
// Stages: unpack/compare, align, add/subtract, normalize.
`timescale 1ns / 1ps
module custom_float_adder (
    input  logic     clk,
    input  logic     rst_n,
    cfa_stream_if.sink   in_a,
    cfa_stream_if.sink   in_b,
    cfa_stream_if.source out_r
);
    import cfa_pkg::*;

    // Both operand channels transfer together.
    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    assign adv = !v4_reg || out_r.ready;
    assign in_a.ready = adv && in_b.valid;
    assign in_b.ready = adv && in_a.valid;
    logic take;
    assign take = in_a.valid && in_b.valid;

    float_t fa, fb;
    assign fa = float_t'(in_a.data);
    assign fb = float_t'(in_b.data);

    // Stage 1: order operands so that the large one has the larger exponent.
    logic             s1l_reg, s1s_reg;
    logic [ExpW-1:0]  e1_reg, d1_reg;
    logic [MantW-1:0] ml1_reg, ms1_reg;
    logic             swap;
    logic [MantW-1:0] ma, mb;
    assign swap = fa.expo < fb.expo;
    assign ma = {fa.expo != '0, fa.frac};
    assign mb = {fb.expo != '0, fb.frac};

    // Stage 2: aligned magnitudes.
    logic             s2l_reg, s2s_reg;
    logic [ExpW-1:0]  e2_reg;
    logic [MantW-1:0] ml2_reg, ms2_reg;

    // Stage 3: summed magnitude.
    logic             s3_reg;
    logic [ExpW:0]    e3_reg;
    logic [SumW-1:0]  m3_reg;
    logic [MantW-1:0] diff_ls, diff_sl;
    assign diff_ls = ml2_reg - ms2_reg;
    assign diff_sl = ms2_reg - ml2_reg;

    // Stage 4 inputs: carry handled, leading-zero count.
    logic [MantW-1:0] mn;
    logic [ExpW:0]    en;
    logic [4:0]       lz;
    logic             lz_found;
    assign mn = m3_reg[SumW-1] ? m3_reg[SumW-1:1] : m3_reg[MantW-1:0];
    assign en = e3_reg + {5'd0, m3_reg[SumW-1]};
    always_comb
    begin
        lz = '0;
        lz_found = 1'b0;
        for (int i = MantW - 1; i >= 0; i--)
        begin
            if (!lz_found && mn[i])
            begin
                lz = 5'(MantW - 1 - i);
                lz_found = 1'b1;
            end
        end
    end
    logic [MantW-1:0] msh;
    assign msh = mn << lz;

    result_t r4_reg, r_next;
    always_comb
    begin
        r_next = '0;
        if (m3_reg == '0)
            r_next = '0;
        else if (en > {1'b0, ExpMax})
        begin
            r_next.sum = {s3_reg, ExpMax, {FracW{1'b0}}};
            r_next.overflowed = 1'b1;
        end
        else if ({1'b0, lz} > en)
            r_next.underflowed = 1'b1;
        else
            r_next.sum = {s3_reg, 5'(en - {1'b0, lz}), msh[FracW-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1l_reg <= swap ? fb.sign : fa.sign;
            s1s_reg <= swap ? fa.sign : fb.sign;
            e1_reg  <= swap ? fb.expo : fa.expo;
            d1_reg  <= swap ? fb.expo - fa.expo : fa.expo - fb.expo;
            ml1_reg <= swap ? mb : ma;
            ms1_reg <= swap ? ma : mb;

            s2l_reg <= s1l_reg;
            s2s_reg <= s1s_reg;
            e2_reg  <= e1_reg;
            ml2_reg <= ml1_reg;
            ms2_reg <= ms1_reg >> d1_reg;

            e3_reg <= {1'b0, e2_reg};
            if (s2l_reg == s2s_reg)
            begin
                m3_reg <= {1'b0, ml2_reg} + {1'b0, ms2_reg};
                s3_reg <= s2l_reg;
            end
            else if (ml2_reg >= ms2_reg)
            begin
                m3_reg <= {1'b0, diff_ls};
                s3_reg <= s2l_reg;
            end
            else
            begin
                m3_reg <= {1'b0, diff_sl};
                s3_reg <= s2s_reg;
            end

            r4_reg <= r_next;
        end
    end

    assign out_r.valid = v4_reg;
    assign out_r.data  = r4_reg;
endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the pipelined custom float adder.
`timescale 1ns / 1ps
module testbench;
    import cfa_pkg::*;

    localparam int Latency = 4;

    logic clk;
    logic rst_n;
    int   fail_count;

    cfa_stream_if #(.payload_t(logic [31:0])) in_a ();
    cfa_stream_if #(.payload_t(logic [31:0])) in_b ();
    cfa_stream_if #(.payload_t(result_t))     out_r ();

    custom_float_adder DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .in_a (in_a),
        .in_b (in_b),
        .out_r(out_r)
    );

    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
        logic        known;
        result_t     sum;
    } addend_row_t;

    result_t     pending_sums[$];
    addend_row_t addend_table[$];
    logic        sending;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Bit-exact prediction of one addition.
    function automatic result_t predict_sum(logic [31:0] a, logic [31:0] b);
        float_t      fa;
        float_t      fb;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] m;
        logic [5:0]  e;
        logic [5:0]  shift;
        logic        s;
        result_t     r;
        fa = a;
        fb = b;
        ma = {6'd0, fa.frac};
        mb = {6'd0, fb.frac};
        if (fa.expo != 0) ma[FracW] = 1'b1;
        if (fb.expo != 0) mb[FracW] = 1'b1;
        if (fa.expo >= fb.expo)
        begin
            mb = mb >> (fa.expo - fb.expo);
            e  = {1'b0, fa.expo};
        end
        else
        begin
            ma = ma >> (fb.expo - fa.expo);
            e  = {1'b0, fb.expo};
        end
        if (fa.sign == fb.sign)
        begin
            m = ma + mb;
            s = fa.sign;
        end
        else if (ma >= mb)
        begin
            m = ma - mb;
            s = fa.sign;
        end
        else
        begin
            m = mb - ma;
            s = fb.sign;
        end
        r = '0;
        if (m != 0)
        begin
            if (m[SumW-1])
            begin
                m = m >> 1;
                e = e + 6'd1;
            end
            if (e > ExpMax)
            begin
                r.overflowed = 1'b1;
                r.sum = {s, ExpMax, {FracW{1'b0}}};
            end
            else
            begin
                shift = '0;
                while (!m[FracW])
                begin
                    m = m << 1;
                    shift = shift + 6'd1;
                end
                if (shift > e)
                begin
                    r.underflowed = 1'b1;
                end
                else
                begin
                    e = e - shift;
                    r.sum = {s, e[ExpW-1:0], m[FracW-1:0]};
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %h, expected %h", what, got, want);
        fail_count++;
    endtask

    function automatic logic [31:0] random_float(bit near);
        float_t f;
        f.sign = 1'($urandom_range(0, 1));
        f.expo = near ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
        f.frac = 26'($urandom);
        if ($urandom_range(0, 7) == 0) f.frac = '0;
        if ($urandom_range(0, 7) == 0) f.frac = '1;
        return f;
    endfunction

    task automatic send_addends(logic [31:0] a, logic [31:0] b, result_t want);
        in_a.valid <= 1'b1;
        in_b.valid <= 1'b1;
        in_a.data  <= a;
        in_b.data  <= b;
        do @(posedge clk); while (!(in_a.ready && in_b.ready));
        pending_sums.push_back(want);
        @(negedge clk);
    endtask

    task automatic drop_valid();
        in_a.valid <= 1'b0;
        in_b.valid <= 1'b0;
    endtask

    task automatic add_row(logic [31:0] a, logic [31:0] b, bit known, result_t sum);
        addend_row_t row;
        row.a = a;
        row.b = b;
        row.known = known;
        row.sum = sum;
        addend_table.push_back(row);
    endtask

    // Result checking against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_r.valid && out_r.ready)
        begin
            if (pending_sums.size() == 0)
            begin
                report_mismatch("unexpected result", out_r.data.sum, 32'h0);
            end
            else
            begin
                result_t want;
                want = pending_sums.pop_front();
                if (out_r.data.sum !== want.sum)
                    report_mismatch("sum", out_r.data.sum, want.sum);
                if (out_r.data.overflowed !== want.overflowed)
                    report_mismatch("overflowed", out_r.data.overflowed, want.overflowed);
                if (out_r.data.underflowed !== want.underflowed)
                    report_mismatch("underflowed", out_r.data.underflowed, want.underflowed);
            end
        end
    end

    // The receiver stalls on a pattern of its own, with stall-free stretches.
    int stall_phase;
    always @(negedge clk)
    begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 300 < 80) out_r.ready <= 1'b1;
        else if (stall_phase % 300 < 160) out_r.ready <= ($urandom_range(0, 3) != 0);
        else out_r.ready <= ($urandom_range(0, 2) == 0);
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int      burst;
        int      n;
        result_t r;
        result_t zero_r;
        result_t ovf_r;
        result_t unf_r;
        fail_count  = 0;
        stall_phase = 0;
        rst_n       = 1'b0;
        in_a.valid  = 1'b0;
        in_b.valid  = 1'b0;
        in_a.data   = '0;
        in_b.data   = '0;
        out_r.ready = 1'b0;
        zero_r = '0;
        ovf_r  = '0;
        ovf_r.overflowed = 1'b1;
        ovf_r.sum = 32'h7C00_0000;
        unf_r  = '0;
        unf_r.underflowed = 1'b1;

        // Directed rows: zeros, cancellation, carry, overflow, underflow, extremes.
        add_row(32'h0000_0000, 32'h0000_0000, 1, zero_r);
        add_row(32'h8000_0000, 32'h8000_0000, 1, zero_r);
        add_row(32'h3C00_0000, 32'hBC00_0000, 1, zero_r);
        add_row(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, zero_r);
        add_row(32'h7C00_0000, 32'h7C00_0000, 1, ovf_r);
        add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, ovf_r);
        add_row(32'h0400_0000, 32'h83FF_FFFF, 0, zero_r);
        add_row(32'h0400_0001, 32'h8400_0000, 1, unf_r);
        add_row(32'h3C00_0000, 32'h3C00_0000, 0, zero_r);
        add_row(32'h3C00_0000, 32'h0000_0001, 0, zero_r);
        add_row(32'h7C00_0000, 32'h0000_0001, 0, zero_r);
        add_row(32'h03FF_FFFF, 32'h03FF_FFFF, 0, zero_r);
        add_row(32'h0000_0001, 32'h8000_0003, 0, zero_r);
        add_row(32'h3FFF_FFFF, 32'hBBFF_FFFF, 0, zero_r);
        add_row(32'h4000_0000, 32'hC3FF_FFFF, 0, zero_r);
        add_row(32'hAAAA_AAAA, 32'h5555_5555, 0, zero_r);
        add_row(32'h5555_5555, 32'hAAAA_AAAA, 0, zero_r);
        add_row(32'h0800_0000, 32'h8400_0000, 0, zero_r);
        add_row(32'h3800_0000, 32'h3C00_0000, 0, zero_r);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (addend_table[i])
        begin
            r = addend_table[i].known ? addend_table[i].sum
                                      : predict_sum(addend_table[i].a, addend_table[i].b);
            send_addends(addend_table[i].a, addend_table[i].b, r);
        end
        drop_valid();

        // Hold off until the pipeline has drained completely.
        wait (pending_sums.size() == 0);
        @(negedge clk);

        n = 0;
        while (n < 550)
        begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && n < 550; k++)
            begin
                logic [31:0] a;
                logic [31:0] b;
                bit near;
                near = ($urandom_range(0, 3) == 0);
                a = random_float(near);
                b = random_float(near);
                // Bias toward cancellation so normalization gets exercised.
                if ($urandom_range(0, 3) == 0)
                begin
                    b = {~a[31], a[30:26], a[25:0] ^ 26'($urandom_range(0, 255))};
                end
                send_addends(a, b, predict_sum(a, b));
                n++;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                drop_valid();
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
        drop_valid();

        wait (pending_sums.size() == 0);
        repeat (Latency + 4) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
